/* rtl/dte_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the sine table of the tone generator.
package dte_pkg;

   localparam int TABLE_DEPTH     = 256;
   localparam int TABLE_AMPLITUDE = 1023;
   localparam int ADDR_W          = $clog2(TABLE_DEPTH);
   localparam int SAMPLE_W        = $clog2(TABLE_AMPLITUDE + 1) + 1;
   localparam int SUM_W           = SAMPLE_W + 1;
   localparam int ACC_W           = 32;
   localparam int LEVEL_W         = 9;
   localparam int CODE_W          = 3;
   localparam int DAC_W           = 16;
   localparam int CSR_INDEX_W     = 2;

   localparam logic [LEVEL_W-1:0] LEVEL_FULL = 9'd255;
   localparam logic [LEVEL_W-1:0] LEVEL_STEP = 9'd2;
   localparam logic [DAC_W-1:0]   CHAN_A_BITS = 16'h3000;
   localparam logic [DAC_W-1:0]   MID_CODE    = 16'd2048;

   localparam logic [CODE_W-1:0] PHASE_IDLE_A    = 3'd0;
   localparam logic [CODE_W-1:0] PHASE_ATTACK_A  = 3'd1;
   localparam logic [CODE_W-1:0] PHASE_SUSTAIN_A = 3'd2;
   localparam logic [CODE_W-1:0] PHASE_RELEASE_A = 3'd3;
   localparam logic [CODE_W-1:0] PHASE_ATTACK_B  = 3'd4;
   localparam logic [CODE_W-1:0] PHASE_SUSTAIN_B = 3'd5;
   localparam logic [CODE_W-1:0] PHASE_RELEASE_B = 3'd6;
   localparam logic [CODE_W-1:0] PHASE_IDLE_B    = 3'd7;

   localparam logic [CSR_INDEX_W-1:0] REG_LOW_INC  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HIGH_INC = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TEST_INC = 2'd2;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [CODE_W-1:0]  code;
   } env_state_type;

   typedef logic signed [SAMPLE_W-1:0] rom_type [TABLE_DEPTH];

   // Q31 angles and rounded-up reciprocals of the Taylor series divisors
   localparam logic [63:0]  PI_Q      = 64'd6746518852;
   localparam logic [63:0]  HALF_PI_Q = 64'd3373259426;
   localparam int           RCP_SHIFT = 73;
   localparam logic [191:0] RCP_ONE   = 192'd1 << RCP_SHIFT;
   localparam logic [191:0] SIN_RCP [10] = '{
      (RCP_ONE + 192'd5) / 192'd6,     (RCP_ONE + 192'd19) / 192'd20,
      (RCP_ONE + 192'd41) / 192'd42,   (RCP_ONE + 192'd71) / 192'd72,
      (RCP_ONE + 192'd109) / 192'd110, (RCP_ONE + 192'd155) / 192'd156,
      (RCP_ONE + 192'd209) / 192'd210, (RCP_ONE + 192'd271) / 192'd272,
      (RCP_ONE + 192'd341) / 192'd342, (RCP_ONE + 192'd419) / 192'd420};

   localparam logic [191:0] ANGLE_DIV   = 192'(1000 * TABLE_DEPTH);
   localparam int           ANGLE_SHIFT = 64 + $clog2(1000 * TABLE_DEPTH);
   localparam logic [191:0] ANGLE_RCP   =
      ((192'd1 << ANGLE_SHIFT) + ANGLE_DIV - 192'd1) / ANGLE_DIV;

   function automatic logic [63:0] sin_q(input logic [63:0] x);
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] acc;
      x2   = (x * x) >> 31;
      term = x;
      acc  = $signed(x);
      for (int n = 1; n <= 10; n++) begin
         term = (term * x2) >> 31;
         term = 64'((192'(term) * SIN_RCP[n-1]) >> RCP_SHIFT);
         if (n[0]) begin
            acc = acc - $signed(term);
         end else begin
            acc = acc + $signed(term);
         end
      end
      if (acc < 0) begin
         acc = 64'sd0;
      end
      return $unsigned(acc);
   endfunction

   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] th;
      logic [63:0] mag;
      logic        neg;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         th  = 64'((192'((64'(k) * 64'd6283) << 31) * ANGLE_RCP) >> ANGLE_SHIFT);
         neg = 1'b0;
         if (th >= PI_Q) begin
            th  = th - PI_Q;
            neg = 1'b1;
         end
         if (th > HALF_PI_Q) begin
            th = (th < PI_Q) ? PI_Q - th : 64'd0;
         end
         mag = (64'(TABLE_AMPLITUDE) * sin_q(th)) >> 31;
         rom[k] = neg ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

endpackage

/* rtl/dte_envelope.sv */
`timescale 1ns / 1ps
// Next-state logic of the ramp envelope: level and phase code for one tick.
module dte_envelope (
   input  dte_pkg::env_state_type cur,
   input  logic                   test_mode,
   input  logic                   key_released,
   output dte_pkg::env_state_type nxt
);

   logic [dte_pkg::LEVEL_W-1:0] lvl_up;
   logic [dte_pkg::LEVEL_W-1:0] lvl_dn;

   assign lvl_up = (cur.level < dte_pkg::LEVEL_FULL) ? cur.level + dte_pkg::LEVEL_STEP
                                                     : cur.level;
   assign lvl_dn = (cur.level >= dte_pkg::LEVEL_STEP) ? cur.level - dte_pkg::LEVEL_STEP
                                                      : '0;

   always_comb begin
      nxt = cur;
      if (test_mode) begin
         nxt.level = key_released ? '0 : dte_pkg::LEVEL_FULL;
      end else begin
         case (cur.code) inside
            dte_pkg::PHASE_ATTACK_A, dte_pkg::PHASE_ATTACK_B: begin
               nxt.level = lvl_up;
               if (lvl_up >= dte_pkg::LEVEL_FULL) begin
                  nxt.code = (cur.code == dte_pkg::PHASE_ATTACK_A) ? dte_pkg::PHASE_SUSTAIN_A
                                                                   : dte_pkg::PHASE_SUSTAIN_B;
               end
            end
            dte_pkg::PHASE_RELEASE_A, dte_pkg::PHASE_RELEASE_B: begin
               // odd residue of one clears now, phase moves on the next tick
               nxt.level = (lvl_dn == 9'd1) ? '0 : lvl_dn;
               if (lvl_dn == '0) begin
                  nxt.code = (cur.code == dte_pkg::PHASE_RELEASE_A) ? dte_pkg::PHASE_IDLE_A
                                                                    : dte_pkg::PHASE_IDLE_B;
               end
            end
            default: begin
               nxt = cur;
            end
         endcase
      end
   end

endmodule

/* rtl/dds_tone_envelope_dac.sv */
`timescale 1ns / 1ps
// Dual-tone DDS generator with ramp envelope and DAC word output.
// A tick beat's result is held in a result register. Throughput: one beat
// per cycle while no held result waits on rsp_tready; the accumulate, sine
// table lookup and 9 x 12 envelope multiply all sit between the state
// registers and the result register. A set-phase beat gives no result.
// Reset (synchronous, active high) clears increments, accumulators, envelope.
module dds_tone_envelope_dac (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // new_phase[2:0], test_mode[3], key_released[4]
   input  logic        req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // dac_word[15:0], envelope_level[24:16],
                                    // envelope_phase[27:25]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int PROD_W  = dte_pkg::SUM_W + dte_pkg::LEVEL_W + 1;
   localparam int SHIFT_W = PROD_W - 8;

   logic [dte_pkg::ACC_W-1:0] low_inc_ff, high_inc_ff, test_inc_ff;
   logic [dte_pkg::ACC_W-1:0] low_ph_ff, high_ph_ff, test_ph_ff;
   logic [dte_pkg::ACC_W-1:0] low_ph_in, high_ph_in, test_ph_in;
   dte_pkg::env_state_type    env_ff, env_in;
   logic                      rsp_valid_ff;
   logic [31:0]               rsp_data_ff, rsp_data_in;

   logic                               req_fire;
   logic                               test_mode;
   logic signed [dte_pkg::SAMPLE_W-1:0] low_s, high_s, test_s;
   logic signed [dte_pkg::SUM_W-1:0]    sum;
   logic signed [PROD_W-1:0]            prod;
   logic signed [SHIFT_W-1:0]           shifted;
   logic [dte_pkg::DAC_W-1:0]           dac_word;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign test_mode  = req_tdata[3];

   dte_envelope u_envelope (
      .cur          (env_ff),
      .test_mode    (test_mode),
      .key_released (req_tdata[4]),
      .nxt          (env_in)
   );

   assign low_ph_in  = low_ph_ff + low_inc_ff;
   assign high_ph_in = high_ph_ff + high_inc_ff;
   assign test_ph_in = test_ph_ff + test_inc_ff;

   assign low_s  = dte_pkg::SINE_ROM[low_ph_in[dte_pkg::ACC_W-1 -: dte_pkg::ADDR_W]];
   assign high_s = dte_pkg::SINE_ROM[high_ph_in[dte_pkg::ACC_W-1 -: dte_pkg::ADDR_W]];
   assign test_s = dte_pkg::SINE_ROM[test_ph_in[dte_pkg::ACC_W-1 -: dte_pkg::ADDR_W]];

   assign sum = test_mode ? dte_pkg::SUM_W'(test_s)
                          : dte_pkg::SUM_W'(low_s) + dte_pkg::SUM_W'(high_s);
   assign prod     = PROD_W'($signed({1'b0, env_in.level})) * PROD_W'(sum);
   assign shifted  = SHIFT_W'(prod >>> 8);
   assign dac_word = dte_pkg::CHAN_A_BITS | (dte_pkg::DAC_W'(shifted) + dte_pkg::MID_CODE);

   assign rsp_data_in = {4'b0, env_in.code, env_in.level, dac_word};

   always_ff @(posedge clock) begin
      if (reset) begin
         low_inc_ff   <= '0;
         high_inc_ff  <= '0;
         test_inc_ff  <= '0;
         low_ph_ff    <= '0;
         high_ph_ff   <= '0;
         test_ph_ff   <= '0;
         env_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               dte_pkg::REG_LOW_INC:  low_inc_ff  <= csr_wdata;
               dte_pkg::REG_HIGH_INC: high_inc_ff <= csr_wdata;
               dte_pkg::REG_TEST_INC: test_inc_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (req_fire && !req_tuser) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_fire) begin
            if (req_tuser) begin
               env_ff.code <= req_tdata[2:0];
            end else begin
               env_ff       <= env_in;
               low_ph_ff    <= low_ph_in;
               high_ph_ff   <= high_ph_in;
               test_ph_ff   <= test_ph_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && !req_tuser) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
